>>> rtl/core/nls_pkg.sv
// ----------------------------------------------------------------------------
// nls_pkg: shared types and constants of the number literal scanner
// Character classes, scanner states, result codes and the option set.
// ----------------------------------------------------------------------------
package nls_pkg;

  localparam logic [7:0] CHR_MINUS  = 8'h2d;
  localparam logic [7:0] CHR_PLUS   = 8'h2b;
  localparam logic [7:0] CHR_PERIOD = 8'h2e;
  localparam logic [7:0] CHR_E      = 8'h65;
  localparam logic [7:0] CHR_X      = 8'h78;
  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_NINE   = 8'h39;
  localparam logic [7:0] CHR_LC_A   = 8'h61;
  localparam logic [7:0] CHR_LC_F   = 8'h66;
  localparam logic [7:0] CHR_UC_A   = 8'h41;
  localparam logic [7:0] CHR_UC_Z   = 8'h5a;
  localparam logic [7:0] CASE_FOLD  = 8'h20;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_ALLOW_SIGN       = 3'd0;
  localparam logic [2:0] REG_ALLOW_FRACTION   = 3'd1;
  localparam logic [2:0] REG_ALLOW_EXPONENT   = 3'd2;
  localparam logic [2:0] REG_ALLOW_ZERO_X_HEX = 3'd3;
  localparam logic [2:0] REG_ALLOW_DOLLAR_HEX = 3'd4;

  typedef enum logic [3:0] {
    CL_ZERO,
    CL_DIGIT,
    CL_PERIOD,
    CL_SIGN,
    CL_E,
    CL_X,
    CL_DOLLAR,
    CL_HEXLET,
    CL_OTHER
  } char_class_t;

  typedef enum logic [3:0] {
    ST_START    = 4'd0,
    ST_SIGN     = 4'd1,
    ST_LEADPER  = 4'd2,
    ST_PERIOD   = 4'd3,
    ST_ZERO     = 4'd4,
    ST_INT      = 4'd5,
    ST_FRAC     = 4'd6,
    ST_EXP      = 4'd7,
    ST_EXPDIG   = 4'd8,
    ST_EXPSIGN  = 4'd9,
    ST_HEXSTART = 4'd10,
    ST_HEX      = 4'd11
  } scan_state_t;

  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_REPLACE = 2'd1,
    ACT_REJECT  = 2'd2,
    ACT_RETURN  = 2'd3
  } char_action_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_INT   = 3'd1,
    KIND_FLOAT = 3'd2,
    KIND_HEX   = 3'd3,
    KIND_ERROR = 3'd4
  } token_kind_t;

  typedef struct packed {
    logic allow_sign;
    logic allow_fraction;
    logic allow_exponent;
    logic allow_zero_x_hex;
    logic allow_dollar_hex;
  } scan_cfg_t;

endpackage

>>> rtl/core/nls_front.sv
// ----------------------------------------------------------------------------
// nls_front: character classifier
// Folds each incoming byte to lower case and reduces it to a class code.
// ----------------------------------------------------------------------------
module nls_front
  import nls_pkg::*;
(
  input  logic [7:0]  char_code,
  output char_class_t char_class
);

  logic [7:0] folded;

  always_comb begin
    if (char_code >= CHR_UC_A && char_code <= CHR_UC_Z) begin
      folded = char_code + CASE_FOLD;
    end else begin
      folded = char_code;
    end
  end

  always_comb begin
    priority if (folded == CHR_ZERO) begin
      char_class = CL_ZERO;
    end else if (folded > CHR_ZERO && folded <= CHR_NINE) begin
      char_class = CL_DIGIT;
    end else if (folded == CHR_PERIOD) begin
      char_class = CL_PERIOD;
    end else if (folded == CHR_PLUS || folded == CHR_MINUS) begin
      char_class = CL_SIGN;
    end else if (folded == CHR_E) begin
      char_class = CL_E;
    end else if (folded == CHR_X) begin
      char_class = CL_X;
    end else if (folded == CHR_DOLLAR) begin
      char_class = CL_DOLLAR;
    end else if (folded >= CHR_LC_A && folded <= CHR_LC_F) begin
      char_class = CL_HEXLET;
    end else begin
      char_class = CL_OTHER;
    end
  end

endmodule

>>> rtl/core/nls_queue.sv
// ----------------------------------------------------------------------------
// nls_queue: class queue between classifier and scanner
// Small register FIFO; a push and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module nls_queue
  import nls_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  char_class_t push_class,
  output logic        not_full,
  input  logic        pop,
  output logic        not_empty,
  output char_class_t pop_class
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  char_class_t       slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_class = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_class;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a push");
`endif

endmodule

>>> rtl/core/nls_back.sv
// ----------------------------------------------------------------------------
// nls_back: literal recognizer and result register
// Steps the scanner state on each class taken from the queue and holds the
// result until the downstream side takes it.
// ----------------------------------------------------------------------------
module nls_back
  import nls_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  scan_cfg_t    cfg,
  input  logic         in_valid,
  input  char_class_t  in_class,
  output logic         in_take,
  output logic         res_valid,
  input  logic         res_ready,
  output char_action_t res_action,
  output logic         res_end,
  output token_kind_t  res_kind
);

  scan_state_t  state;
  scan_state_t  state_next;
  scan_state_t  step_state;
  char_action_t act;
  logic         tok_end;
  token_kind_t  kind;
  logic         is_dec;
  logic         is_hex;

  assign is_dec  = (in_class == CL_ZERO) || (in_class == CL_DIGIT);
  assign is_hex  = is_dec || (in_class == CL_E) || (in_class == CL_HEXLET);
  assign in_take = in_valid && (!res_valid || res_ready);

  // Next state while the token goes on; an ending token overrides it below.
  always_comb begin
    step_state = state;
    unique case (state)
      ST_SIGN: begin
        if (in_class == CL_ZERO) step_state = ST_ZERO;
        else if (cfg.allow_fraction && in_class == CL_PERIOD) step_state = ST_PERIOD;
        else if (in_class == CL_DIGIT) step_state = ST_INT;
      end
      ST_LEADPER: begin
        if (is_dec) step_state = ST_FRAC;
      end
      ST_PERIOD: begin
        if (is_dec) step_state = ST_FRAC;
        else if (cfg.allow_exponent && in_class == CL_E) step_state = ST_EXP;
      end
      ST_ZERO: begin
        if (in_class == CL_DIGIT) step_state = ST_INT;
        else if (cfg.allow_fraction && in_class == CL_PERIOD) step_state = ST_PERIOD;
        else if (cfg.allow_zero_x_hex && in_class == CL_X) step_state = ST_HEXSTART;
      end
      ST_INT: begin
        if (cfg.allow_fraction && in_class == CL_PERIOD) step_state = ST_PERIOD;
        else if (cfg.allow_exponent && in_class == CL_E) step_state = ST_EXP;
      end
      ST_FRAC: begin
        if (cfg.allow_exponent && in_class == CL_E) step_state = ST_EXP;
      end
      ST_EXP: begin
        if (in_class == CL_SIGN) step_state = ST_EXPSIGN;
        else if (is_dec) step_state = ST_EXPDIG;
      end
      ST_EXPDIG: begin
        step_state = ST_EXPDIG;
      end
      ST_EXPSIGN: begin
        if (is_dec) step_state = ST_EXPDIG;
      end
      ST_HEXSTART: begin
        if (is_hex) step_state = ST_HEX;
      end
      ST_HEX: begin
        step_state = ST_HEX;
      end
      default: begin
        if (cfg.allow_sign && in_class == CL_SIGN) step_state = ST_SIGN;
        else if (in_class == CL_ZERO) step_state = ST_ZERO;
        else if (in_class == CL_DIGIT) step_state = ST_INT;
        else if (cfg.allow_fraction && in_class == CL_PERIOD) step_state = ST_LEADPER;
        else if (cfg.allow_dollar_hex && in_class == CL_DOLLAR) step_state = ST_HEXSTART;
        else step_state = ST_START;
      end
    endcase
    state_next = tok_end ? ST_START : step_state;
  end

  // Result of the current character.
  always_comb begin
    act     = ACT_APPEND;
    tok_end = 1'b0;
    kind    = KIND_NONE;
    unique case (state)
      ST_SIGN: begin
        tok_end = !(is_dec || (cfg.allow_fraction && in_class == CL_PERIOD));
      end
      ST_LEADPER: begin
        tok_end = !is_dec;
      end
      ST_PERIOD: begin
        if (!is_dec && !(cfg.allow_exponent && in_class == CL_E)) begin
          tok_end = 1'b1;
          kind    = KIND_INT;
        end
      end
      ST_ZERO: begin
        if (is_dec) begin
          act = ACT_REPLACE;
        end else if (!(cfg.allow_fraction && in_class == CL_PERIOD) &&
                     !(cfg.allow_zero_x_hex && in_class == CL_X)) begin
          tok_end = 1'b1;
          kind    = KIND_INT;
        end
      end
      ST_INT: begin
        if (!(cfg.allow_fraction && in_class == CL_PERIOD) &&
            !(cfg.allow_exponent && in_class == CL_E) && !is_dec) begin
          tok_end = 1'b1;
          kind    = KIND_INT;
        end
      end
      ST_FRAC: begin
        if (!(cfg.allow_exponent && in_class == CL_E) && !is_dec) begin
          tok_end = 1'b1;
          kind    = KIND_FLOAT;
        end
      end
      ST_EXP: begin
        if (in_class != CL_SIGN && !is_dec) begin
          tok_end = 1'b1;
          kind    = KIND_ERROR;
        end
      end
      ST_EXPDIG: begin
        if (!is_dec) begin
          tok_end = 1'b1;
          kind    = KIND_FLOAT;
        end
      end
      ST_EXPSIGN, ST_HEXSTART: begin
        if ((state == ST_EXPSIGN) ? !is_dec : !is_hex) begin
          tok_end = 1'b1;
          kind    = KIND_ERROR;
        end
      end
      ST_HEX: begin
        if (!is_hex) begin
          tok_end = 1'b1;
          kind    = KIND_HEX;
        end
      end
      default: begin
        tok_end = !((cfg.allow_sign && in_class == CL_SIGN) || is_dec ||
                    (cfg.allow_fraction && in_class == CL_PERIOD) ||
                    (cfg.allow_dollar_hex && in_class == CL_DOLLAR));
      end
    endcase
    // A period left dangling after digits or a sign is handed back in place of the reject.
    if (tok_end) begin
      act = (state == ST_PERIOD) ? ACT_RETURN : ACT_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_START;
      res_valid <= 1'b0;
    end else begin
      if (in_take) begin
        state     <= state_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_action <= act;
      res_end    <= tok_end;
      res_kind   <= kind;
    end
  end

`ifndef SYNTH
  a_kind_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_end) |-> res_kind == KIND_NONE)
    else $error("token kind given without token end");

  a_return_is_int: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_action == ACT_RETURN) |-> (res_end && res_kind == KIND_INT))
    else $error("period given back outside an integer end");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_take && tok_end) |=> state == ST_START)
    else $error("scanner did not restart after a token end");
`endif

endmodule

>>> rtl/core/number_literal_scanner.sv
// A character accepted on s_tdata is classified, registered in the class queue and then
// in the result register that drives m_tvalid; a stall downstream holds it in the queue.
// The scanner takes one character per cycle while m_tready keeps the results moving.
// The class queue lets the input keep flowing while a result waits downstream.
// Reset (rst, synchronous): scanner at the start state, queue and result
// register empty, options at their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// number_literal_scanner: streaming recognizer for numeric literals
// Classifies each character, queues the class and steps the literal scanner,
// giving one result per character.
// ----------------------------------------------------------------------------
module number_literal_scanner
  import nls_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [1:0] char_action, [7:2] zero
  output logic       m_tlast,   // token_end
  output logic [2:0] m_tuser,   // [2:0] token_kind
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic       cfg_data
);

  scan_cfg_t    cfg;
  char_class_t  front_class;
  char_class_t  queue_class;
  logic         queue_not_full;
  logic         queue_not_empty;
  logic         back_take;
  char_action_t res_action;
  token_kind_t  res_kind;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.allow_sign       <= 1'b1;
      cfg.allow_fraction   <= 1'b1;
      cfg.allow_exponent   <= 1'b1;
      cfg.allow_zero_x_hex <= 1'b1;
      cfg.allow_dollar_hex <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ALLOW_SIGN:       cfg.allow_sign       <= cfg_data;
        REG_ALLOW_FRACTION:   cfg.allow_fraction   <= cfg_data;
        REG_ALLOW_EXPONENT:   cfg.allow_exponent   <= cfg_data;
        REG_ALLOW_ZERO_X_HEX: cfg.allow_zero_x_hex <= cfg_data;
        REG_ALLOW_DOLLAR_HEX: cfg.allow_dollar_hex <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = queue_not_full;

  nls_front u_front (
    .char_code  (s_tdata),
    .char_class (front_class)
  );

  nls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid && queue_not_full),
    .push_class (front_class),
    .not_full   (queue_not_full),
    .pop        (back_take),
    .not_empty  (queue_not_empty),
    .pop_class  (queue_class)
  );

  nls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (queue_not_empty),
    .in_class   (queue_class),
    .in_take    (back_take),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_action (res_action),
    .res_end    (m_tlast),
    .res_kind   (res_kind)
  );

  assign m_tdata = {6'b0, res_action};
  assign m_tuser = res_kind;

endmodule

>>> tb/sv/nls_checker.sv
// ----------------------------------------------------------------------------
// nls_checker: result predictor and scoreboard for the number literal scanner
// Watches the character, result and option channels, steps its own copy of
// the literal scanner for every accepted character and compares each result
// beat with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nls_checker
  import nls_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [1:0] char_action, [7:2] zero
  input  logic       m_tlast,   // token_end
  input  logic [2:0] m_tuser,   // [2:0] token_kind
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic       cfg_data,
  output int         mismatch_count,
  output int         pending_results,
  output int         results_checked,
  output int         tokens_closed
);

  typedef struct packed {
    char_action_t action;
    logic         token_end;
    token_kind_t  kind;
  } scan_result_t;

  scan_cfg_t    options;
  scan_state_t  scan_pos;
  scan_result_t predicted_q[$];
  int           fail_total;
  int           result_total;
  int           token_total;

  // One step of the literal recognizer: result for this character and the
  // state that the next character starts from.
  function automatic scan_result_t scan_char(input logic [7:0] raw, input scan_cfg_t opt,
                                             input scan_state_t cur,
                                             output scan_state_t nxt);
    logic [7:0]   c;
    logic         dec;
    logic         hex;
    logic         done;
    scan_result_t r;
    c = raw;
    if (c >= CHR_UC_A && c <= CHR_UC_Z) c = c + CASE_FOLD;
    dec = (c >= CHR_ZERO && c <= CHR_NINE);
    hex = dec || (c >= CHR_LC_A && c <= CHR_LC_F);
    r.action = ACT_APPEND;
    r.kind   = KIND_NONE;
    done     = 1'b0;
    nxt      = cur;
    case (cur)
      ST_SIGN: begin
        if (c == CHR_ZERO) nxt = ST_ZERO;
        else if (opt.allow_fraction && c == CHR_PERIOD) nxt = ST_PERIOD;
        else if (dec) nxt = ST_INT;
        else done = 1'b1;
      end
      ST_LEADPER: begin
        if (dec) nxt = ST_FRAC;
        else done = 1'b1;
      end
      ST_PERIOD: begin
        if (dec) nxt = ST_FRAC;
        else if (opt.allow_exponent && c == CHR_E) nxt = ST_EXP;
        else begin
          done = 1'b1;
          r.kind = KIND_INT;
          r.action = ACT_RETURN;
        end
      end
      ST_ZERO: begin
        if (c == CHR_ZERO) r.action = ACT_REPLACE;
        else if (dec) begin
          r.action = ACT_REPLACE;
          nxt = ST_INT;
        end else if (opt.allow_fraction && c == CHR_PERIOD) nxt = ST_PERIOD;
        else if (opt.allow_zero_x_hex && c == CHR_X) nxt = ST_HEXSTART;
        else begin
          done = 1'b1;
          r.kind = KIND_INT;
        end
      end
      ST_INT: begin
        if (opt.allow_fraction && c == CHR_PERIOD) nxt = ST_PERIOD;
        else if (opt.allow_exponent && c == CHR_E) nxt = ST_EXP;
        else if (!dec) begin
          done = 1'b1;
          r.kind = KIND_INT;
        end
      end
      ST_FRAC: begin
        if (opt.allow_exponent && c == CHR_E) nxt = ST_EXP;
        else if (!dec) begin
          done = 1'b1;
          r.kind = KIND_FLOAT;
        end
      end
      ST_EXP: begin
        if (c == CHR_PLUS || c == CHR_MINUS) nxt = ST_EXPSIGN;
        else if (dec) nxt = ST_EXPDIG;
        else begin
          done = 1'b1;
          r.kind = KIND_ERROR;
        end
      end
      ST_EXPDIG: begin
        if (!dec) begin
          done = 1'b1;
          r.kind = KIND_FLOAT;
        end
      end
      ST_EXPSIGN: begin
        if (dec) nxt = ST_EXPDIG;
        else begin
          done = 1'b1;
          r.kind = KIND_ERROR;
        end
      end
      ST_HEXSTART: begin
        if (hex) nxt = ST_HEX;
        else begin
          done = 1'b1;
          r.kind = KIND_ERROR;
        end
      end
      ST_HEX: begin
        if (!hex) begin
          done = 1'b1;
          r.kind = KIND_HEX;
        end
      end
      default: begin
        if (opt.allow_sign && (c == CHR_MINUS || c == CHR_PLUS)) nxt = ST_SIGN;
        else if (c == CHR_ZERO) nxt = ST_ZERO;
        else if (dec) nxt = ST_INT;
        else if (opt.allow_fraction && c == CHR_PERIOD) nxt = ST_LEADPER;
        else if (opt.allow_dollar_hex && c == CHR_DOLLAR) nxt = ST_HEXSTART;
        else done = 1'b1;
      end
    endcase
    // A finished token always restarts; its action is a reject unless a period is handed back.
    if (done) begin
      if (r.action != ACT_RETURN) r.action = ACT_REJECT;
      nxt = ST_START;
    end
    r.token_end = done;
    return r;
  endfunction

  task automatic note_failure(input string why);
    fail_total++;
    if (fail_total <= 10) $display("%0t ns: %s", $time, why);
  endtask

  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    scan_state_t  nxt;
    if (rst) begin
      options.allow_sign       = 1'b1;
      options.allow_fraction   = 1'b1;
      options.allow_exponent   = 1'b1;
      options.allow_zero_x_hex = 1'b1;
      options.allow_dollar_hex = 1'b0;
      scan_pos = ST_START;
      predicted_q.delete();
    end else begin
      // The result beat is matched first: it can never belong to a character
      // accepted at the same edge.
      if (m_tvalid && m_tready) begin
        got.action    = char_action_t'(m_tdata[1:0]);
        got.token_end = m_tlast;
        got.kind      = token_kind_t'(m_tuser);
        result_total++;
        if (m_tlast) token_total++;
        if (predicted_q.size() == 0) begin
          note_failure($sformatf("result beat with nothing predicted: action %0d end %0b kind %0d",
                                 got.action, got.token_end, got.kind));
        end else begin
          want = predicted_q.pop_front();
          if (got.action !== want.action || got.token_end !== want.token_end ||
              got.kind !== want.kind) begin
            note_failure($sformatf({"result %0d: expected action %0d end %0b kind %0d, ",
                                    "got action %0d end %0b kind %0d"},
                                   result_total, want.action, want.token_end, want.kind,
                                   got.action, got.token_end, got.kind));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = scan_char(s_tdata, options, scan_pos, nxt);
        predicted_q.push_back(want);
        scan_pos = nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ALLOW_SIGN:       options.allow_sign       = cfg_data;
          REG_ALLOW_FRACTION:   options.allow_fraction   = cfg_data;
          REG_ALLOW_EXPONENT:   options.allow_exponent   = cfg_data;
          REG_ALLOW_ZERO_X_HEX: options.allow_zero_x_hex = cfg_data;
          REG_ALLOW_DOLLAR_HEX: options.allow_dollar_hex = cfg_data;
          default: ;
        endcase
      end
    end
    mismatch_count  <= fail_total;
    pending_results <= predicted_q.size();
    results_checked <= result_total;
    tokens_closed   <= token_total;
  end

  initial begin
    fail_total   = 0;
    result_total = 0;
    token_total  = 0;
  end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the number literal scanner
// Feeds directed corner strings and then random literals, broken literals and
// noise bytes under changing option settings and back-pressure, while the
// checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import nls_pkg::*;

  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_SEMI  = 8'h3b;
  localparam logic [7:0] CHR_LC_G  = 8'h67;
  localparam logic [7:0] CHR_LC_Z  = 8'h7a;
  localparam int         SEG_CHARS = 68;
  localparam int         SEGMENTS  = 6;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;    // [7:0] char_code
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;            // [1:0] char_action, [7:2] zero
  logic       m_tlast;            // token_end
  logic [2:0] m_tuser;            // [2:0] token_kind
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = 3'd0;
  logic       cfg_data = 1'b0;

  int mismatch_count;
  int pending_results;
  int results_checked;
  int tokens_closed;

  int         send_idle_pct = 9;
  int         recv_idle_pct = 56;
  int         chars_sent = 0;
  int         option_sets = 0;
  logic [7:0] char_q[$];

  number_literal_scanner u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  nls_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .m_tuser        (m_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results),
    .results_checked(results_checked),
    .tokens_closed  (tokens_closed)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    #200000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i]);
  endtask

  // Holds the character stream until every predicted result has come back or the wait limit runs out.
  task automatic wait_results_drained();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_results != 0 && waited < 5000);
  endtask

  task automatic apply_options(input scan_cfg_t opt);
    logic [2:0] idx[5];
    logic       val[5];
    idx = '{REG_ALLOW_SIGN, REG_ALLOW_FRACTION, REG_ALLOW_EXPONENT,
            REG_ALLOW_ZERO_X_HEX, REG_ALLOW_DOLLAR_HEX};
    val = '{opt.allow_sign, opt.allow_fraction, opt.allow_exponent,
            opt.allow_zero_x_hex, opt.allow_dollar_hex};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    option_sets++;
  endtask

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CHR_LC_A && c <= CHR_LC_Z && $urandom_range(0, 1)) return c - CASE_FOLD;
    return c;
  endfunction

  task automatic push_digits(input int lo, input int hi, input bit hexdigits);
    int n;
    int v;
    n = $urandom_range(hi, lo);
    for (int i = 0; i < n; i++) begin
      if (hexdigits) begin
        v = $urandom_range(0, 15);
        char_q.push_back(v < 10 ? 8'(CHR_ZERO + v) : fold_case(8'(CHR_LC_A + v - 10)));
      end else begin
        char_q.push_back(8'(CHR_ZERO + $urandom_range(0, 9)));
      end
    end
  endtask

  // Queues one literal, a broken literal, a jumble of number characters or a
  // noise byte, most of them followed by something that ends the token.
  task automatic queue_token();
    string jumble;
    int    form;
    jumble = "0123456789.+-eExX$";
    form = $urandom_range(0, 19);
    if (form < 3) begin
      char_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 2) == 0) char_q.push_back($urandom_range(0, 1) ? CHR_PLUS : CHR_MINUS);
    case (form)
      3, 4: push_digits(1, 5, 0);
      5: begin
        repeat ($urandom_range(1, 3)) char_q.push_back(CHR_ZERO);
        push_digits(0, 3, 0);
      end
      6, 7: begin
        push_digits(1, 3, 0);
        char_q.push_back(CHR_PERIOD);
        push_digits(0, 3, 0);
      end
      8: begin
        char_q.push_back(CHR_PERIOD);
        push_digits(1, 3, 0);
      end
      9, 10: begin
        push_digits(1, 3, 0);
        if ($urandom_range(0, 1)) begin
          char_q.push_back(CHR_PERIOD);
          push_digits(0, 2, 0);
        end
        char_q.push_back(fold_case(CHR_E));
        if ($urandom_range(0, 1)) char_q.push_back($urandom_range(0, 1) ? CHR_PLUS : CHR_MINUS);
        push_digits(1, 3, 0);
      end
      11, 12: begin
        char_q.push_back(CHR_ZERO);
        char_q.push_back(fold_case(CHR_X));
        push_digits(1, 4, 1);
      end
      13, 14: begin
        char_q.push_back(CHR_DOLLAR);
        push_digits(1, 4, 1);
      end
      15: begin
        char_q.push_back(CHR_ZERO);
        char_q.push_back(fold_case(CHR_E));
      end
      16, 17: begin
        case ($urandom_range(0, 5))
          0: begin
            push_digits(1, 2, 0);
            char_q.push_back(fold_case(CHR_E));
          end
          1: begin
            push_digits(1, 2, 0);
            char_q.push_back(fold_case(CHR_E));
            char_q.push_back($urandom_range(0, 1) ? CHR_PLUS : CHR_MINUS);
          end
          2: begin
            char_q.push_back(CHR_ZERO);
            char_q.push_back(fold_case(CHR_X));
          end
          3: begin
            push_digits(1, 3, 0);
            char_q.push_back(CHR_PERIOD);
          end
          4: char_q.push_back(CHR_DOLLAR);
          default: char_q.push_back(CHR_PERIOD);
        endcase
      end
      default: begin
        repeat ($urandom_range(2, 6)) char_q.push_back(jumble[$urandom_range(0, jumble.len() - 1)]);
      end
    endcase
    case ($urandom_range(0, 4))
      0: char_q.push_back(CHR_SPACE);
      1: char_q.push_back(CHR_SEMI);
      2: char_q.push_back(8'($urandom_range(0, 255)));
      3: char_q.push_back(fold_case(8'($urandom_range(CHR_LC_Z, CHR_LC_G))));
      default: ;
    endcase
  endtask

  initial begin
    int        seg_start;
    scan_cfg_t opt;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corner strings under the reset options: every state, upper case folding,
    // dangling period, zero before e, a bad exponent, bad hex prefix, lone sign
    // and lone period, and both extreme byte values.
    send_text("+07.5E-3 0Xg12.");
    send_char(8'hff);
    send_text("0e1e+;+");
    send_char(8'h00);
    send_text(".q0x1F#");
    wait_results_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct <= 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct <= 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      if (seg == 0) opt = '1;
      else if (seg == 1) opt = '0;
      else opt = scan_cfg_t'(5'($urandom_range(0, 31)));
      apply_options(opt);
      seg_start = chars_sent;
      while (chars_sent - seg_start < SEG_CHARS) begin
        queue_token();
        while (char_q.size() != 0) send_char(char_q.pop_front());
      end
      wait_results_drained();
    end
    repeat (8) @(posedge clk);

    $display("Sent %0d characters under %0d option settings and three back-pressure mixes.",
             chars_sent, option_sets);
    $display("Checked %0d result beats, %0d of them closing a token.",
             results_checked, tokens_closed);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/nls_pkg.sv
rtl/core/nls_front.sv
rtl/core/nls_queue.sv
rtl/core/nls_back.sv
rtl/core/number_literal_scanner.sv
tb/sv/nls_checker.sv
tb/sv/tb.sv
